>>> rtl/core/descriptor_handle_allocator_core_macros.svh
// assertion helpers for the checker file
`ifndef DESCRIPTOR_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define DESCRIPTOR_HANDLE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, quiet while in reset
`define DHA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dha check failed");

// next-cycle implication, quiet while in reset
`define DHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dha check failed");

// next-cycle implication that also covers the reset itself
`define DHA_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dha check failed");

`endif

>>> rtl/core/dha_pkg.sv
`default_nettype none

package dha_pkg;

  localparam int IDX_W  = 8;
  localparam int CAP_W  = 9;
  localparam int ESZ_W  = 13;
  localparam int ADDR_W = 64;
  localparam int PROD_W = IDX_W + ESZ_W;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_HANDLES  = 2'd1,
    ST_NONE_ACTIVE = 2'd2
  } status_t;

  localparam logic [1:0] CFG_HEAP_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_BASE_ADDRESS  = 2'd1;
  localparam logic [1:0] CFG_ENTRY_SIZE    = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET  = 9'd256;
  localparam logic [ESZ_W-1:0] ESZ_RESET  = 13'd32;

  // stack request from the decision logic
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] data;
  } stk_ctl_t;

  // decided transaction waiting for its address
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [PROD_W-1:0] prod;
    logic              got;
    status_t           status;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/dha_stack.sv
`default_nettype none

// lifo of freed indices: top entry in a register, the rest in a memory,
// the entry below the top prefetched into rd_r every cycle
module dha_stack #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  dha_pkg::stk_ctl_t                       ctl,
  output logic [$clog2(MAX_SLOTS+1)-1:0]          depth,
  output logic [dha_pkg::IDX_W-1:0]               top
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int DW = $clog2(MAX_SLOTS + 1);
  localparam logic [DW-1:0] FULL = DW'(MAX_SLOTS);
  localparam logic [DW-1:0] ONE  = DW'(1);
  localparam logic [DW-1:0] TWO  = DW'(2);

  logic [dha_pkg::IDX_W-1:0] mem [MAX_SLOTS];
  logic [DW-1:0]             depth_r, depth_nxt;
  logic [dha_pkg::IDX_W-1:0] top_r, top_nxt;
  logic [dha_pkg::IDX_W-1:0] rd_r;
  logic                      push_ok;
  logic                      wr_en;
  logic [DW-1:0]             wr_full, rd_full;
  logic [AW-1:0]             wr_addr, rd_addr;

  always_comb begin
    push_ok   = ctl.push && (depth_r < FULL);
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (push_ok) begin
      depth_nxt = depth_r + ONE;
      top_nxt   = ctl.data;
    end else if (ctl.pop) begin
      depth_nxt = depth_r - ONE;
      top_nxt   = rd_r;
    end
    // old top sinks into the memory on a push
    wr_en   = push_ok && (depth_r != '0);
    wr_full = depth_r - ONE;
    wr_addr = wr_full[AW-1:0];
    rd_full = depth_nxt - TWO;
    rd_addr = rd_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    // forward the entry written this cycle
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_r <= top_r;
    end else begin
      rd_r <= mem[rd_addr];
    end
  end

  assign depth = depth_r;
  assign top   = top_r;

endmodule

`default_nettype wire

>>> rtl/core/dha_addr.sv
`default_nettype none

// output stage: base plus scaled index (zero if no slot), held until taken
module dha_addr (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         res_valid,
  output logic                         res_ready,
  input  dha_pkg::res_t                res,
  input  logic [dha_pkg::ADDR_W-1:0]   base,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dha_pkg::IDX_W-1:0]    out_slot_index,
  output logic [dha_pkg::ADDR_W-1:0]   out_slot_address,
  output logic [1:0]                   out_status
);

  logic                        valid_r;
  logic [dha_pkg::IDX_W-1:0]   idx_r;
  logic [dha_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [1:0]                  status_r;

  assign res_ready = !valid_r || out_ready;
  assign addr_nxt  = res.got ? (base + dha_pkg::ADDR_W'(res.prod)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      idx_r    <= res.idx;
      addr_r   <= addr_nxt;
      status_r <= res.status;
    end
  end

  assign out_valid        = valid_r;
  assign out_slot_index   = idx_r;
  assign out_slot_address = addr_r;
  assign out_status       = status_r;

endmodule

`default_nettype wire

>>> rtl/core/descriptor_handle_allocator_core.sv
// Handle slot allocator. Each transaction is either an allocate or a free and
// yields exactly one result. An allocate hands out the next never-used slot
// while it is below min(heap_capacity, MAX_SLOTS), otherwise the most recently
// freed slot, and reports base_address + index * entry_size; running dry gives
// status 1, a free with no active handles gives status 2, and neither changes
// state. One transaction is taken every clock cycle while results are taken,
// with no stall of its own; each result passes the input, decision and
// output registers. The free list lives in a MAX_SLOTS x 8 memory with its
// top entry held in a register, so back-to-back pops and pushes run at full
// rate. The memory needs no clearing after reset. The user is to write
// configuration only while no transaction is in flight; it is not checked.
`default_nettype none

module descriptor_handle_allocator_core #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [dha_pkg::IDX_W-1:0]    in_freed_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dha_pkg::IDX_W-1:0]    out_slot_index,
  output logic [dha_pkg::ADDR_W-1:0]   out_slot_address,
  output logic [1:0]                   out_status,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [dha_pkg::ADDR_W-1:0]   cfg_wdata
);

  localparam int DW = $clog2(MAX_SLOTS + 1);
  localparam logic [31:0] MAX_W = 32'(MAX_SLOTS);

  // configuration
  logic [dha_pkg::CAP_W-1:0]   cap_r;
  logic [dha_pkg::ADDR_W-1:0]  base_r;
  logic [dha_pkg::ESZ_W-1:0]   esize_r;

  // input register
  logic                        s1_valid_r;
  logic                        s1_op_r;
  logic [dha_pkg::IDX_W-1:0]   s1_freed_r;

  // allocator state
  logic [dha_pkg::CAP_W-1:0]   fresh_r, fresh_nxt;
  logic [dha_pkg::CAP_W-1:0]   active_r, active_nxt;

  // decision register
  logic                        s2_valid_r;
  dha_pkg::res_t               s2_res_r, res_nxt;
  logic                        s2_ready;
  logic                        addr_ready;
  logic                        fire;

  dha_pkg::stk_ctl_t           stk_ctl;
  logic [DW-1:0]               stk_depth;
  logic [dha_pkg::IDX_W-1:0]   stk_top;
  logic                        fresh_ok;
  logic [dha_pkg::IDX_W-1:0]   idx_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= dha_pkg::CAP_RESET;
      base_r  <= '0;
      esize_r <= dha_pkg::ESZ_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dha_pkg::CFG_HEAP_CAPACITY: cap_r   <= cfg_wdata[dha_pkg::CAP_W-1:0];
        dha_pkg::CFG_BASE_ADDRESS:  base_r  <= cfg_wdata;
        dha_pkg::CFG_ENTRY_SIZE:    esize_r <= cfg_wdata[dha_pkg::ESZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign s2_ready = !s2_valid_r || addr_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign fire     = s1_valid_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= in_op;
      s1_freed_r <= in_freed_index;
    end
  end

  // decide the transaction held in the input register
  always_comb begin
    fresh_ok       = (fresh_r < cap_r) && (32'(fresh_r) < MAX_W);
    fresh_nxt      = fresh_r;
    active_nxt     = active_r;
    stk_ctl.push   = 1'b0;
    stk_ctl.pop    = 1'b0;
    stk_ctl.data   = s1_freed_r;
    idx_sel        = '0;
    res_nxt.got    = 1'b0;
    res_nxt.status = dha_pkg::ST_OK;
    if (s1_op_r == dha_pkg::OP_ALLOC) begin
      if (fresh_ok) begin
        idx_sel     = fresh_r[dha_pkg::IDX_W-1:0];
        fresh_nxt   = fresh_r + 1'b1;
        active_nxt  = active_r + 1'b1;
        res_nxt.got = 1'b1;
      end else if (stk_depth != '0) begin
        idx_sel     = stk_top;
        stk_ctl.pop = fire;
        active_nxt  = active_r + 1'b1;
        res_nxt.got = 1'b1;
      end else begin
        res_nxt.status = dha_pkg::ST_NO_HANDLES;
      end
    end else begin
      if (active_r == '0) begin
        res_nxt.status = dha_pkg::ST_NONE_ACTIVE;
      end else begin
        stk_ctl.push = fire;
        active_nxt   = active_r - 1'b1;
      end
    end
    res_nxt.idx  = idx_sel;
    res_nxt.prod = dha_pkg::PROD_W'(idx_sel) * dha_pkg::PROD_W'(esize_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r    <= '0;
      active_r   <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        fresh_r  <= fresh_nxt;
        active_r <= active_nxt;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s2_res_r <= res_nxt;
    end
  end

  dha_stack #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .depth (stk_depth),
    .top   (stk_top)
  );

  dha_addr u_addr (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (s2_valid_r),
    .res_ready        (addr_ready),
    .res              (s2_res_r),
    .base             (base_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_index   (out_slot_index),
    .out_slot_address (out_slot_address),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

>>> rtl/core/dha_checker.sv
`default_nettype none

`include "descriptor_handle_allocator_core_macros.svh"

module dha_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [dha_pkg::IDX_W-1:0]    out_slot_index,
  input wire logic [dha_pkg::ADDR_W-1:0]   out_slot_address,
  input wire logic [1:0]                   out_status
);

  // a stalled result holds its payload
  `DHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slot_index) && $stable(out_slot_address) && $stable(out_status))

  // errors carry no slot
  `DHA_ASSERT_IMPLY(a_err_zero, out_valid && out_status != dha_pkg::ST_OK, out_slot_index == '0 && out_slot_address == '0)

  // nothing leaves the block right after reset
  `DHA_ASSERT_NEXT_ALWAYS(a_rst_idle, !rst_n, !out_valid)

endmodule

bind descriptor_handle_allocator_core dha_checker u_dha_checker (.*);

`default_nettype wire

>>> verif/dha_grant_checker.sv
`default_nettype none

module dha_grant_checker #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_op,
  input  logic [dha_pkg::IDX_W-1:0]           in_freed_index,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [dha_pkg::IDX_W-1:0]           out_slot_index,
  input  logic [dha_pkg::ADDR_W-1:0]          out_slot_address,
  input  logic [1:0]                          out_status,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [dha_pkg::ADDR_W-1:0]          cfg_wdata,
  output int                                  mismatches,
  output int                                  grants_owed,
  output int                                  results_seen,
  output int                                  refusals_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = $clog2(MAX_SLOTS) + 1;

  typedef struct packed {
    logic [dha_pkg::IDX_W-1:0]  idx;
    logic [dha_pkg::ADDR_W-1:0] addr;
    dha_pkg::status_t           status;
  } grant_t;

  grant_t                     grant_q[$];

  logic [dha_pkg::CAP_W-1:0]  capacity_reg;
  logic [dha_pkg::ADDR_W-1:0] base_reg;
  logic [dha_pkg::ESZ_W-1:0]  stride_reg;

  logic [CNT_W-1:0]           fresh_next;
  logic [CNT_W-1:0]           stack_depth;
  logic [CNT_W-1:0]           live_handles;
  logic [dha_pkg::IDX_W-1:0]  freed_stack [MAX_SLOTS];

  // advances the allocator state by one request and returns its result
  function automatic grant_t predict_grant(dha_pkg::op_t op,
                                           logic [dha_pkg::IDX_W-1:0] freed_idx);
    grant_t g;
    int     limit;
    logic   got;
    g     = '{idx: '0, addr: '0, status: dha_pkg::ST_OK};
    got   = 1'b0;
    limit = (capacity_reg > MAX_SLOTS) ? MAX_SLOTS : int'(capacity_reg);
    if (op == dha_pkg::OP_ALLOC) begin
      if (fresh_next < limit) begin
        g.idx      = fresh_next[dha_pkg::IDX_W-1:0];
        fresh_next = fresh_next + 1'b1;
        got        = 1'b1;
      end else if (stack_depth != 0) begin
        stack_depth = stack_depth - 1'b1;
        g.idx       = freed_stack[stack_depth];
        got         = 1'b1;
      end
      if (got) begin
        live_handles = live_handles + 1'b1;
        g.addr       = base_reg + dha_pkg::ADDR_W'(g.idx) * dha_pkg::ADDR_W'(stride_reg);
      end else begin
        g.status = dha_pkg::ST_NO_HANDLES;
      end
    end else begin
      if (live_handles == 0) begin
        g.status = dha_pkg::ST_NONE_ACTIVE;
      end else begin
        // full stack cannot occur, but a push there would be dropped
        if (stack_depth < MAX_SLOTS) begin
          freed_stack[stack_depth] = freed_idx;
          stack_depth              = stack_depth + 1'b1;
        end
        live_handles = live_handles - 1'b1;
      end
    end
    return g;
  endfunction

  task automatic report_field(string name, logic [dha_pkg::ADDR_W-1:0] want,
                              logic [dha_pkg::ADDR_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    grant_t g;
    grant_t pred;
    if (!rst_n) begin
      capacity_reg = dha_pkg::CAP_RESET;
      base_reg     = '0;
      stride_reg   = dha_pkg::ESZ_RESET;
      fresh_next   = '0;
      stack_depth  = '0;
      live_handles = '0;
      grant_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          dha_pkg::CFG_HEAP_CAPACITY: capacity_reg = cfg_wdata[dha_pkg::CAP_W-1:0];
          dha_pkg::CFG_BASE_ADDRESS:  base_reg     = cfg_wdata;
          dha_pkg::CFG_ENTRY_SIZE:    stride_reg   = cfg_wdata[dha_pkg::ESZ_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred    = predict_grant(dha_pkg::op_t'(in_op), in_freed_index);
        grant_q = {grant_q, pred};
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (grant_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, expected none actual idx 0x%0h status %0d",
                   $time, out_slot_index, out_status);
        end else begin
          g = grant_q.pop_front();
          if (g.status != dha_pkg::ST_OK)
            refusals_seen++;
          report_field("slot_index", dha_pkg::ADDR_W'(g.idx),
                       dha_pkg::ADDR_W'(out_slot_index));
          report_field("slot_address", g.addr, out_slot_address);
          report_field("status", dha_pkg::ADDR_W'(g.status), dha_pkg::ADDR_W'(out_status));
        end
      end
    end
    grants_owed = grant_q.size();
  end

endmodule

`default_nettype wire

>>> verif/tb_descriptor_handle_allocator_core.sv
`default_nettype none

module tb_descriptor_handle_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic                         in_op          = 1'b0;
  logic [dha_pkg::IDX_W-1:0]    in_freed_index = '0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic [dha_pkg::IDX_W-1:0]    out_slot_index;
  logic [dha_pkg::ADDR_W-1:0]   out_slot_address;
  logic [1:0]                   out_status;
  logic                         cfg_wr_en      = 1'b0;
  logic [1:0]                   cfg_index      = dha_pkg::CFG_HEAP_CAPACITY;
  logic [dha_pkg::ADDR_W-1:0]   cfg_wdata      = '0;

  int mismatches;
  int grants_owed;
  int results_seen;
  int refusals_seen;

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int rx_hold_len   = 0;
  int requests_sent = 0;
  int settings_used = 0;

  always #10 clk = ~clk;

  descriptor_handle_allocator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_freed_index   (in_freed_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_index   (out_slot_index),
    .out_slot_address (out_slot_address),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  dha_grant_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_freed_index   (in_freed_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_index   (out_slot_index),
    .out_slot_address (out_slot_address),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .grants_owed      (grants_owed),
    .results_seen     (results_seen),
    .refusals_seen    (refusals_seen)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_request(dha_pkg::op_t op, logic [dha_pkg::IDX_W-1:0] idx);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_freed_index <= idx;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // wait until every transaction has its result, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (grants_owed != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [dha_pkg::CAP_W-1:0] cap, logic [dha_pkg::ADDR_W-1:0] base,
                            logic [dha_pkg::ESZ_W-1:0] stride);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= dha_pkg::CFG_HEAP_CAPACITY;
    cfg_wdata <= dha_pkg::ADDR_W'(cap);
    @(posedge clk);
    cfg_index <= dha_pkg::CFG_BASE_ADDRESS;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= dha_pkg::CFG_ENTRY_SIZE;
    cfg_wdata <= dha_pkg::ADDR_W'(stride);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [dha_pkg::IDX_W-1:0] pick_index();
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      default: return dha_pkg::IDX_W'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int phase_items;
    int kind;
    int burst;
    int pct;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 20;
    rx_idle_pct = 88;

    // reset settings: free with nothing live, fresh allocations, unchecked frees
    send_request(dha_pkg::OP_FREE, 8'hFF);
    send_request(dha_pkg::OP_ALLOC, 8'h00);
    send_request(dha_pkg::OP_ALLOC, 8'hFF);
    send_request(dha_pkg::OP_FREE, 8'hFF);
    send_request(dha_pkg::OP_FREE, 8'h00);
    send_request(dha_pkg::OP_FREE, 8'h55);
    send_request(dha_pkg::OP_ALLOC, 8'h00);
    send_request(dha_pkg::OP_FREE, 8'hAA);

    // zero capacity: stack only, wrapping address, then running dry
    set_config(9'd0, '1, 13'd8191);
    send_request(dha_pkg::OP_ALLOC, 8'h00);
    send_request(dha_pkg::OP_ALLOC, 8'h00);
    send_request(dha_pkg::OP_ALLOC, 8'h00);
    send_request(dha_pkg::OP_ALLOC, 8'h00);
    send_request(dha_pkg::OP_FREE, 8'h80);
    send_request(dha_pkg::OP_FREE, 8'h7F);

    // capacity above the table size and zero stride
    set_config(9'd511, 64'h8000_0000_0000_0000, 13'd0);
    send_request(dha_pkg::OP_ALLOC, 8'h00);
    send_request(dha_pkg::OP_ALLOC, 8'h00);

    // capacity lowered below what was handed out
    set_config(9'd1, 64'h0123_4567_89AB_CDEF, 13'd4096);
    send_request(dha_pkg::OP_ALLOC, 8'h00);
    send_request(dha_pkg::OP_FREE, 8'h3C);
    send_request(dha_pkg::OP_ALLOC, 8'h00);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 3) begin
        tx_idle_pct = 20;
        rx_idle_pct = 88;
      end else if (phase < 6) begin
        tx_idle_pct = 88;
        rx_idle_pct = 20;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (phase)
        0: set_config(9'd256, {$urandom, $urandom}, 13'd32);
        1: set_config(9'd8, {$urandom, $urandom},
                      dha_pkg::ESZ_W'($urandom_range(1, 8191)));
        2: set_config(9'd511, '1, 13'd8191);
        3: set_config(9'd0, '0, 13'd0);
        4: set_config(dha_pkg::CAP_W'($urandom_range(1, 300)), {$urandom, $urandom}, 13'd1);
        5: set_config(9'd1, {$urandom, $urandom}, 13'd4096);
        6: begin
          set_config(9'd256, '0, dha_pkg::ESZ_W'($urandom_range(8191)));
          // back-pressure: results held while requests keep coming
          rx_hold_len = 250;
        end
        default: set_config(dha_pkg::CAP_W'($urandom_range(511)), {$urandom, $urandom},
                            dha_pkg::ESZ_W'($urandom_range(8191)));
      endcase

      phase_items = 0;
      while (phase_items < 230) begin
        kind = $urandom_range(3);
        if (kind == 3) begin
          burst = $urandom_range(1, 16);
          repeat (burst) send_request(dha_pkg::OP_ALLOC, pick_index());
          repeat (burst) send_request(dha_pkg::OP_FREE, pick_index());
          phase_items += 2 * burst;
        end else begin
          pct = (kind == 0) ? 25 : (kind == 1) ? 50 : 80;
          repeat (40)
            send_request(($urandom_range(99) < pct) ? dha_pkg::OP_ALLOC : dha_pkg::OP_FREE,
                         pick_index());
          phase_items += 40;
        end
      end
    end

    settle();
    $display("covered %0d allocate/free transactions over %0d register settings",
             requests_sent, settings_used);
    $display("compared %0d results, %0d of them refusals", results_seen, refusals_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results still owed", grants_owed);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
